// ===== src/msg_hdr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msg_hdr_pkg;

  localparam int unsigned HdrMinLen  = 8;
  localparam int unsigned NodeIdLen  = 8;
  localparam int unsigned GroupIdLen = 2;

  localparam logic [1:0] DsizNone     = 2'd0;
  localparam logic [1:0] DsizNode     = 2'd1;
  localparam logic [1:0] DsizGroup    = 2'd2;
  localparam logic [1:0] SessTypeGroup = 2'd1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TRUNCATED = 2'd1,
    STATUS_INVALID   = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  flags_byte;
    logic [15:0] sess_id;
    logic [7:0]  sec_flags;
    logic [31:0] msg_counter;
    logic [63:0] source_node;
    logic [63:0] dest_node;
    logic [15:0] dest_group;
    logic [4:0]  header_length;
    logic        is_secure;
  } out_t;

endpackage

`default_nettype wire

// ===== src/message_header_parser.sv =====
// Timing: a result transaction is registered and presented in the cycle after the byte that decides it.
// Throughput: one byte per cycle, set by the single output register; the input is
// stalled only while that register holds a result that has not been taken.
// Reset: asynchronous, active low; clears the byte position, the skip flag, the gathered
// header fields and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module message_header_parser
  import msg_hdr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic [4:0]  idx_q, idx_d;
  logic        done_q, done_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] session_q, session_d;
  logic [7:0]  security_q, security_d;
  logic [31:0] counter_q, counter_d;
  logic [63:0] source_q, source_d;
  logic [63:0] dnode_q, dnode_d;
  logic [15:0] dgroup_q, dgroup_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  logic        accept;
  logic [7:0]  b;
  logic [4:0]  pos;
  logic [5:0]  count;
  logic [4:0]  dst;
  logic [4:0]  off;
  logic [4:0]  need;
  logic        s_flag;
  logic [1:0]  dsiz;
  logic        have_min;
  logic        produce;
  out_t        res;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign b      = in_data_i.rx_byte;
  assign pos    = idx_q;
  assign count  = {1'b0, idx_q} + 6'd1;
  assign s_flag = flags_q[2];
  assign dsiz   = flags_q[1:0];
  assign dst    = s_flag ? 5'(HdrMinLen + NodeIdLen) : 5'(HdrMinLen);
  assign off    = pos - dst;

  always_comb begin
    if (idx_q == 5'd0) begin
      flags_d    = '0;
      session_d  = '0;
      security_d = '0;
      counter_d  = '0;
      source_d   = '0;
      dnode_d    = '0;
      dgroup_d   = '0;
    end else begin
      flags_d    = flags_q;
      session_d  = session_q;
      security_d = security_q;
      counter_d  = counter_q;
      source_d   = source_q;
      dnode_d    = dnode_q;
      dgroup_d   = dgroup_q;
    end
    if (!done_q) begin
      if (pos == 5'd0) begin
        flags_d = b;
      end else if (pos == 5'd1) begin
        session_d[7:0] = b;
      end else if (pos == 5'd2) begin
        session_d[15:8] = b;
      end else if (pos == 5'd3) begin
        security_d = b;
      end else if (pos < 5'(HdrMinLen)) begin
        for (int k = 0; k < 4; k++) begin
          if (pos[1:0] == 2'(k)) begin
            counter_d[8*k +: 8] = b;
          end
        end
      end else if (s_flag && pos < 5'(HdrMinLen + NodeIdLen)) begin
        for (int k = 0; k < 8; k++) begin
          if (pos[2:0] == 3'(k)) begin
            source_d[8*k +: 8] = b;
          end
        end
      end else if (pos >= dst) begin
        if (dsiz == DsizNode && off < 5'(NodeIdLen)) begin
          for (int k = 0; k < 8; k++) begin
            if (off[2:0] == 3'(k)) begin
              dnode_d[8*k +: 8] = b;
            end
          end
        end else if (dsiz == DsizGroup && off < 5'(GroupIdLen)) begin
          if (off[0]) begin
            dgroup_d[15:8] = b;
          end else begin
            dgroup_d[7:0] = b;
          end
        end
      end
    end
  end

  always_comb begin
    have_min = count >= 6'(HdrMinLen);
    need     = 5'(HdrMinLen);
    if (flags_d[7:4] != 4'd0) begin
      need = 5'd0;
    end else begin
      if (flags_d[2]) begin
        need = need + 5'(NodeIdLen);
      end
      case (flags_d[1:0])
        DsizNone:  need = need;
        DsizNode:  need = need + 5'(NodeIdLen);
        DsizGroup: need = need + 5'(GroupIdLen);
        default:   need = 5'd0;
      endcase
    end

    res     = '0;
    produce = 1'b1;
    if (have_min && need == 5'd0) begin
      res.status     = STATUS_INVALID;
      res.flags_byte = flags_d;
    end else if (have_min && count == {1'b0, need}) begin
      res.status        = STATUS_OK;
      res.flags_byte    = flags_d;
      res.sess_id       = session_d;
      res.sec_flags     = security_d;
      res.msg_counter   = counter_d;
      res.source_node   = source_d;
      res.dest_node     = dnode_d;
      res.dest_group    = dgroup_d;
      res.header_length = need;
      res.is_secure     = (security_d[1:0] == SessTypeGroup) || (session_d != 16'd0);
    end else if (in_data_i.last_byte) begin
      res.status     = STATUS_TRUNCATED;
      res.flags_byte = have_min ? flags_d : 8'd0;
    end else begin
      produce = 1'b0;
    end
    if (done_q) begin
      produce = 1'b0;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (accept) begin
      if (done_q) begin
        if (in_data_i.last_byte) begin
          idx_d  = 5'd0;
          done_d = 1'b0;
        end
      end else begin
        if (idx_q != 5'd31) begin
          idx_d = count[4:0];
        end
        if (produce) begin
          out_valid_d = 1'b1;
          out_d       = res;
          if (in_data_i.last_byte) begin
            idx_d  = 5'd0;
            done_d = 1'b0;
          end else begin
            done_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      session_q   <= '0;
      security_q  <= '0;
      counter_q   <= '0;
      source_q    <= '0;
      dnode_q     <= '0;
      dgroup_q    <= '0;
    end else begin
      idx_q       <= idx_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        flags_q    <= flags_d;
        session_q  <= session_d;
        security_q <= security_d;
        counter_q  <= counter_d;
        source_q   <= source_d;
        dnode_q    <= dnode_d;
        dgroup_q   <= dgroup_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire
